FILE: rtl/core/acf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acf_pkg;

    localparam int FRAGMENT_SIZE_DEFAULT = 255;

    localparam logic [7:0] CLASS_RESET = 8'h80;
    localparam logic [7:0] INSTR_RESET = 8'hE2;

    localparam logic [7:0] P1_MORE = 8'h11;
    localparam logic [7:0] P1_LAST = 8'h91;
    localparam logic [7:0] LE_BYTE = 8'h00;

    localparam logic FUNC_BEGIN   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    localparam logic REG_CLASS = 1'b0;
    localparam logic REG_INSTR = 1'b1;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_LE      = 2'd2;

    // position of the current word within one item's run of results
    typedef enum logic [6:0] {
        ST_CLA  = 7'b0000001,
        ST_INS  = 7'b0000010,
        ST_P1   = 7'b0000100,
        ST_BLK  = 7'b0001000,
        ST_LEN  = 7'b0010000,
        ST_DATA = 7'b0100000,
        ST_LE   = 7'b1000000
    } step_t;

    typedef struct packed {
        logic       has_hdr;
        logic       has_data;
        logic       has_le;
        logic       p1_last;
        logic [7:0] block;
        logic [7:0] frag_len;
        logic [7:0] data;
    } run_t;

endpackage

`default_nettype wire

FILE: rtl/core/apdu_command_fragmenter.sv
// Pipeline: two register stages, the run register and then the result register.
// Throughput: an item that causes N words (N = 0..7) holds the input until its last word
// is loaded; each fragment opens with the five-word header, then its payload words pass at
// one per cycle while m_ready is high. The rate is set by the single result register stage.
// Reset (aresetn, synchronous, active low): no message, counters zero, class 0x80, ins 0xE2.
`timescale 1ns / 1ps
`default_nettype none

module apdu_command_fragmenter
    import acf_pkg::*;
#(
    parameter int FRAGMENT_SIZE = FRAGMENT_SIZE_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [15:0] s_message_length,
    input  wire logic [7:0]  s_data_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_byte_kind,
    output logic             m_last_of_run,
    output logic             m_message_done
);

    localparam logic [15:0] FRAG_W16 = 16'(FRAGMENT_SIZE);
    localparam logic [7:0]  FRAG_LEN = 8'(FRAGMENT_SIZE);

    logic [7:0]  class_reg, instr_reg;
    logic        active_reg, active_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  block_reg, block_next;

    logic        run_valid_reg, run_valid_next;
    run_t        run_reg, run_next;
    step_t       step_reg, step_next;

    logic        m_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  kind_reg;
    logic        last_reg, done_reg;

    logic        accept, out_load, run_last;
    logic        produce;
    run_t        new_run;
    logic [15:0] remain_dec;
    logic [8:0]  offset_inc;
    logic        more_frags;
    logic [7:0]  sel_byte;
    logic [1:0]  sel_kind;
    step_t       adv_step;

    assign out_load = run_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !run_valid_reg || (out_load && run_last);
    assign accept   = s_valid && s_ready;

    assign remain_dec = remain_reg - 16'd1;
    assign offset_inc = {1'b0, offset_reg} + 9'd1;

    // header fields for a fragment starting now (begin item: from the new length)
    always_comb begin
        logic [15:0] basis;
        basis = (s_func == FUNC_BEGIN) ? s_message_length : remain_reg;
        more_frags       = basis > FRAG_W16;
        new_run.has_hdr  = 1'b0;
        new_run.has_data = 1'b0;
        new_run.has_le   = 1'b0;
        new_run.p1_last  = !more_frags;
        new_run.block    = (s_func == FUNC_BEGIN) ? 8'd0 : block_reg;
        new_run.frag_len = more_frags ? FRAG_LEN : basis[7:0];
        new_run.data     = s_data_byte;
        produce          = 1'b0;
        active_next      = active_reg;
        remain_next      = remain_reg;
        offset_next      = offset_reg;
        block_next       = block_reg;

        if (accept) begin
            if (s_func == FUNC_BEGIN) begin
                remain_next = s_message_length;
                offset_next = 8'd0;
                block_next  = 8'd0;
                active_next = (s_message_length != 16'd0);
                if (s_message_length == 16'd0) begin
                    produce        = 1'b1;
                    new_run.has_hdr = 1'b1;
                    new_run.has_le  = 1'b1;
                end
            end else if (active_reg && remain_reg != 16'd0) begin
                produce          = 1'b1;
                new_run.has_hdr  = (offset_reg == 8'd0);
                new_run.has_data = 1'b1;
                new_run.has_le   = (remain_dec == 16'd0);
                remain_next      = remain_dec;
                if (offset_inc >= {1'b0, FRAG_LEN} || remain_dec == 16'd0) begin
                    offset_next = 8'd0;
                    block_next  = block_reg + 8'd1;
                end else begin
                    offset_next = offset_inc[7:0];
                end
                if (remain_dec == 16'd0) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    // result sequencing over the stored run
    always_comb begin
        sel_byte = LE_BYTE;
        sel_kind = KIND_LE;
        adv_step = ST_LE;
        run_last = 1'b0;
        unique case (step_reg)
            ST_CLA: begin
                sel_byte = class_reg;
                sel_kind = KIND_HEADER;
                adv_step = ST_INS;
            end
            ST_INS: begin
                sel_byte = instr_reg;
                sel_kind = KIND_HEADER;
                adv_step = ST_P1;
            end
            ST_P1: begin
                sel_byte = run_reg.p1_last ? P1_LAST : P1_MORE;
                sel_kind = KIND_HEADER;
                adv_step = ST_BLK;
            end
            ST_BLK: begin
                sel_byte = run_reg.block;
                sel_kind = KIND_HEADER;
                adv_step = ST_LEN;
            end
            ST_LEN: begin
                sel_byte = run_reg.frag_len;
                sel_kind = KIND_HEADER;
                adv_step = run_reg.has_data ? ST_DATA : ST_LE;
            end
            ST_DATA: begin
                sel_byte = run_reg.data;
                sel_kind = KIND_PAYLOAD;
                adv_step = ST_LE;
                run_last = !run_reg.has_le;
            end
            ST_LE: begin
                sel_byte = LE_BYTE;
                sel_kind = KIND_LE;
                adv_step = ST_LE;
                run_last = 1'b1;
            end
            default: begin
                sel_byte = LE_BYTE;
                sel_kind = KIND_LE;
                adv_step = ST_LE;
                run_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        step_next      = step_reg;
        if (out_load) begin
            if (run_last) begin
                run_valid_next = 1'b0;
            end else begin
                step_next = adv_step;
            end
        end
        if (accept && produce) begin
            run_valid_next = 1'b1;
            run_next       = new_run;
            step_next      = new_run.has_hdr ? ST_CLA : ST_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_reg     <= CLASS_RESET;
            instr_reg     <= INSTR_RESET;
            active_reg    <= 1'b0;
            remain_reg    <= 16'd0;
            offset_reg    <= 8'd0;
            block_reg     <= 8'd0;
            run_valid_reg <= 1'b0;
            step_reg      <= ST_LE;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CLASS: class_reg <= cfg_data;
                    REG_INSTR: instr_reg <= cfg_data;
                    default:   class_reg <= class_reg;
                endcase
            end
            active_reg    <= active_next;
            remain_reg    <= remain_next;
            offset_reg    <= offset_next;
            block_reg     <= block_next;
            run_valid_reg <= run_valid_next;
            step_reg      <= step_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        run_reg <= run_next;
        if (out_load) begin
            out_byte_reg <= sel_byte;
            kind_reg     <= sel_kind;
            last_reg     <= run_last;
            done_reg     <= (step_reg == ST_LE);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_byte_kind    = kind_reg;
    assign m_last_of_run  = last_reg;
    assign m_message_done = done_reg;

    // an active message always has bytes left to take
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (remain_reg != 16'd0))
        else $error("active message with no bytes remaining");

    assert property (@(posedge aclk) disable iff (!aresetn)
        offset_reg < FRAG_LEN)
        else $error("fragment offset out of range");

    // a new word is only taken once the pending run hands over its last result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && run_valid_reg) |-> (out_load && run_last))
        else $error("input accepted over an unfinished run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_message_done) |-> (m_last_of_run && m_byte_kind == KIND_LE))
        else $error("message end not on a final Le word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        run_valid_reg |-> $onehot(step_reg))
        else $error("run step not one-hot");

endmodule

`default_nettype wire
